>>> rtl/frce_pkg.sv
`timescale 1ns / 1ps
package frce_pkg;

   localparam int AddrBits = 16;
   localparam int NumRegs  = 4;
   localparam int RegIdxW  = 2;

   localparam logic [7:0] OP_NOP  = 8'd0;
   localparam logic [7:0] OP_HALT = 8'd1;
   localparam logic [7:0] OP_MOVRR = 8'd2;
   localparam logic [7:0] OP_MOVRM = 8'd3;
   localparam logic [7:0] OP_MOVMR = 8'd4;
   localparam logic [7:0] OP_MOVRI = 8'd5;
   localparam logic [7:0] OP_MOVMI = 8'd6;
   localparam logic [7:0] OP_ADD  = 8'd7;
   localparam logic [7:0] OP_SUB  = 8'd8;
   localparam logic [7:0] OP_CMP  = 8'd9;
   localparam logic [7:0] OP_JMP  = 8'd10;
   localparam logic [7:0] OP_JZ   = 8'd11;
   localparam logic [7:0] OP_JG   = 8'd12;
   localparam logic [7:0] OP_JL   = 8'd13;
   localparam logic [7:0] OP_OUT  = 8'd14;
   localparam logic [7:0] OP_INC  = 8'd15;
   localparam logic [7:0] OP_DEC  = 8'd16;
   localparam logic [7:0] OP_MUL  = 8'd17;
   localparam logic [7:0] OP_DIV  = 8'd18;

   localparam logic [2:0] ERR_OK      = 3'd0;
   localparam logic [2:0] ERR_BAD_REG = 3'd1;
   localparam logic [2:0] ERR_LOAD    = 3'd2;
   localparam logic [2:0] ERR_DIV0    = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN = 3'd4;

   localparam logic CSR_START  = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   typedef struct packed {
      logic [7:0]  mode;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      logic signed [31:0] load_data;
      logic        resume;
   } req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        mem_write;
      logic [15:0] mem_addr;
      logic signed [31:0] mem_data;
      logic        out_valid;
      logic signed [31:0] out_value;
      logic        halted;
      logic [2:0]  error_code;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request, read operands
      logic execute;   // non-iterative ops: commit result
      logic div_start; // start iterative multiply/divide
      logic div_step;  // one iteration
      logic div_done;  // commit long op result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_long;   // needs iterative unit
      logic iter_last; // final iteration this cycle
   } sts_type;

endpackage

>>> rtl/frce_ctrl.sv
`timescale 1ns / 1ps
module frce_ctrl import frce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_ITER = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.is_long) begin
               cmd.div_start = 1'b1;
               state_in      = ST_ITER;
            end else if (!rsp_valid_in) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ITER: begin
            cmd.div_step = 1'b1;
            if (sts.iter_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_in) begin
               cmd.div_done = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/frce_dp.sv
`timescale 1ns / 1ps
module frce_dp import frce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     rsp_data
);

   logic [31:0] regs_ff [NumRegs];
   logic [31:0] flag_ff;
   logic [AddrBits-1:0] pc_ff;
   logic        stop_ff;
   logic [15:0] length_ff;
   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] opa_ff, opb_ff;
   logic [RegIdxW-1:0] ia, ib;
   logic        ra, rb;

   // iterative unit: shift-add multiply or restoring divide, one bit a cycle
   logic [31:0] acc_ff, quo_ff, mcand_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic [32:0] trial;
   logic [31:0] mag_a, mag_b, long_res;

   logic [AddrBits-1:0] npc, pc1, pc2, pc3;
   logic [31:0] wval;
   logic        wen;
   logic        is_long_op;

   assign ia = req_ff.operand_a[RegIdxW-1:0];
   assign ib = req_ff.operand_b[RegIdxW-1:0];
   assign ra = req_ff.operand_a < 32'(NumRegs);
   assign rb = req_ff.operand_b < 32'(NumRegs);
   assign is_long_op = !stop_ff && ra && rb &&
      (req_ff.mode == OP_MUL || (req_ff.mode == OP_DIV && opb_ff != 32'd0));
   assign sts.is_long   = is_long_op;
   assign sts.iter_last = (cnt_ff == 6'd31);

   assign mag_a = opa_ff[31] ? (32'd0 - opa_ff) : opa_ff;
   assign mag_b = opb_ff[31] ? (32'd0 - opb_ff) : opb_ff;
   assign trial = {acc_ff, quo_ff[31]} - {1'b0, mcand_ff};
   assign long_res = (req_ff.mode == OP_MUL) ? acc_ff :
                     (neg_ff ? (32'd0 - quo_ff) : quo_ff);

   assign pc1 = pc_ff + AddrBits'(1);
   assign pc2 = pc_ff + AddrBits'(2);
   assign pc3 = pc_ff + AddrBits'(3);

   always_comb begin
      rsp_in = '0;
      npc    = pc_ff;
      wen    = 1'b0;
      wval   = '0;
      if (!stop_ff) begin
         if (req_ff.mode <= OP_HALT) npc = pc1;
         else if (req_ff.mode == OP_OUT || req_ff.mode == OP_INC ||
                  req_ff.mode == OP_DEC) npc = pc2;
         else if (req_ff.mode <= OP_DIV) npc = pc3;
         case (req_ff.mode)
            OP_NOP: ;
            OP_HALT: if (!req_ff.resume) npc = pc_ff;
            OP_MOVRR: if (ra && rb) begin wen = 1'b1; wval = opb_ff; end
                      else rsp_in.error_code = ERR_BAD_REG;
            OP_MOVRM: if (!ra) rsp_in.error_code = ERR_BAD_REG;
                      else if (req_ff.operand_b > 32'(length_ff)) begin
                         wen = 1'b1; wval = req_ff.load_data;
                      end else rsp_in.error_code = ERR_LOAD;
            OP_MOVMR: if (rb) begin
                         rsp_in.mem_write = 1'b1;
                         rsp_in.mem_addr  = 16'(req_ff.operand_a[AddrBits-1:0]);
                         rsp_in.mem_data  = opb_ff;
                      end else rsp_in.error_code = ERR_BAD_REG;
            OP_MOVRI: if (ra) begin wen = 1'b1; wval = req_ff.operand_b; end
                      else rsp_in.error_code = ERR_BAD_REG;
            OP_MOVMI: begin
               rsp_in.mem_write = 1'b1;
               rsp_in.mem_addr  = 16'(req_ff.operand_a[AddrBits-1:0]);
               rsp_in.mem_data  = req_ff.operand_b;
            end
            OP_ADD: if (ra && rb) begin wen = 1'b1; wval = opa_ff + opb_ff; end
                    else rsp_in.error_code = ERR_BAD_REG;
            OP_SUB: if (ra && rb) begin wen = 1'b1; wval = opa_ff - opb_ff; end
                    else rsp_in.error_code = ERR_BAD_REG;
            OP_CMP, OP_MUL: if (!(ra && rb)) rsp_in.error_code = ERR_BAD_REG;
            OP_DIV: if (!(ra && rb)) rsp_in.error_code = ERR_BAD_REG;
                    else if (opb_ff == 32'd0) rsp_in.error_code = ERR_DIV0;
            OP_JMP: npc = req_ff.operand_a[AddrBits-1:0];
            OP_JZ, OP_JG, OP_JL: begin
               if ((req_ff.mode == OP_JZ && flag_ff == 32'd0) ||
                   (req_ff.mode == OP_JG && !flag_ff[31] && flag_ff != 32'd0) ||
                   (req_ff.mode == OP_JL && flag_ff[31]))
                  npc = pc1 + req_ff.operand_a[AddrBits-1:0];
               else
                  npc = pc2;
            end
            OP_OUT: if (ra) begin rsp_in.out_valid = 1'b1; rsp_in.out_value = opa_ff; end
                    else rsp_in.error_code = ERR_BAD_REG;
            OP_INC: if (ra) begin wen = 1'b1; wval = opa_ff + 32'd1; end
                    else rsp_in.error_code = ERR_BAD_REG;
            OP_DEC: if (ra) begin wen = 1'b1; wval = opa_ff - 32'd1; end
                    else rsp_in.error_code = ERR_BAD_REG;
            default: begin
               rsp_in.error_code = ERR_UNKNOWN;
               npc = pc_ff;
            end
         endcase
      end
      rsp_in.next_pc = 16'(npc);
      rsp_in.halted  = stop_ff ||
         (req_ff.mode == OP_HALT && !req_ff.resume) || req_ff.mode > OP_DIV;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
         opa_ff <= regs_ff[req_data.operand_a[RegIdxW-1:0]];
         opb_ff <= regs_ff[req_data.operand_b[RegIdxW-1:0]];
      end
      if (cmd.div_start) begin
         cnt_ff <= '0;
         neg_ff <= opa_ff[31] ^ opb_ff[31];
         acc_ff <= '0;
         if (req_ff.mode == OP_MUL) begin
            quo_ff <= opb_ff; mcand_ff <= opa_ff;
         end else begin
            quo_ff <= mag_a; mcand_ff <= mag_b;
         end
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (req_ff.mode == OP_MUL) begin
            acc_ff <= (acc_ff << 1) + (quo_ff[31] ? mcand_ff : 32'd0);
            quo_ff <= quo_ff << 1;
         end else if (!trial[32]) begin
            acc_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            acc_ff <= {acc_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.execute || cmd.div_done) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
         flag_ff   <= '0;
         pc_ff     <= '0;
         stop_ff   <= 1'b0;
         length_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_START) begin
            pc_ff    <= csr_wdata[AddrBits-1:0];
            stop_ff  <= 1'b0;
         end else begin
            length_ff <= csr_wdata;
         end
      end else if (cmd.execute || cmd.div_done) begin
         pc_ff   <= npc;
         stop_ff <= rsp_in.halted;
         if (cmd.div_done) regs_ff[ia] <= long_res;
         else if (wen) regs_ff[ia] <= wval;
         if (!stop_ff && req_ff.mode == OP_CMP && ra && rb)
            flag_ff <= opa_ff - opb_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/four_register_cpu_execute.sv
`timescale 1ns / 1ps
// Requests are captured in IDLE and executed in EXEC; MUL and DIV then run 32
// iterations of a shared shift-add/subtract unit (ITER) and commit in DONE.
// No new request is taken until the current one is done; the response
// register frees the request side once the result is latched.
// Synchronous active-high reset clears registers, flag, PC and halt state.
module four_register_cpu_execute import frce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   frce_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   frce_dp u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import frce_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_START;
   logic [15:0] csr_wdata = '0;

   four_register_cpu_execute u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // machine state mirrored in the testbench
   logic [31:0] cpu_regs [NumRegs];
   logic [31:0] cmp_flag;
   logic [15:0] cpu_pc;
   logic        cpu_stopped;
   logic [15:0] cfg_length;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      failures = 0;
   int      idle_cycles = 0;
   int      hold_off = 0;
   int      send_gap = 0;
   bit      run_done = 0;

   function automatic logic [31:0] signed_quotient(logic [31:0] x, logic [31:0] y);
      logic [31:0] mx, my, q;
      mx = x[31] ? -x : x;
      my = y[31] ? -y : y;
      q = mx / my;
      return (x[31] != y[31]) ? -q : q;
   endfunction

   function automatic rsp_type execute_instr(req_type r);
      rsp_type     o;
      logic [31:0] npc, a, b;
      logic        ra, rb, neg, take;
      logic [1:0]  ia, ib;
      o = '0;
      a = r.operand_a;
      b = r.operand_b;
      ra = a < NumRegs;
      rb = b < NumRegs;
      ia = a[1:0];
      ib = b[1:0];
      npc = {16'd0, cpu_pc};
      if (!cpu_stopped) begin
         if (r.mode <= OP_HALT) npc = cpu_pc + 1;
         else if (r.mode == OP_OUT || r.mode == OP_INC || r.mode == OP_DEC) npc = cpu_pc + 2;
         else if (r.mode <= OP_DIV) npc = cpu_pc + 3;
         case (r.mode)
            OP_NOP: ;
            OP_HALT: if (!r.resume) begin
               cpu_stopped = 1'b1;
               npc = cpu_pc;
            end
            OP_MOVRR: if (ra && rb) cpu_regs[ia] = cpu_regs[ib]; else o.error_code = ERR_BAD_REG;
            OP_MOVRM: begin
               if (!ra) o.error_code = ERR_BAD_REG;
               else if (b > cfg_length) cpu_regs[ia] = r.load_data;
               else o.error_code = ERR_LOAD;
            end
            OP_MOVMR: if (rb) begin
               o.mem_write = 1'b1;
               o.mem_addr = a[15:0];
               o.mem_data = cpu_regs[ib];
            end else o.error_code = ERR_BAD_REG;
            OP_MOVRI: if (ra) cpu_regs[ia] = b; else o.error_code = ERR_BAD_REG;
            OP_MOVMI: begin
               o.mem_write = 1'b1;
               o.mem_addr = a[15:0];
               o.mem_data = b;
            end
            OP_ADD, OP_SUB, OP_CMP, OP_MUL, OP_DIV: begin
               if (!(ra && rb)) o.error_code = ERR_BAD_REG;
               else if (r.mode == OP_ADD) cpu_regs[ia] = cpu_regs[ia] + cpu_regs[ib];
               else if (r.mode == OP_SUB) cpu_regs[ia] = cpu_regs[ia] - cpu_regs[ib];
               else if (r.mode == OP_CMP) cmp_flag = cpu_regs[ia] - cpu_regs[ib];
               else if (r.mode == OP_MUL) cpu_regs[ia] = cpu_regs[ia] * cpu_regs[ib];
               else if (cpu_regs[ib] == 0) o.error_code = ERR_DIV0;
               else cpu_regs[ia] = signed_quotient(cpu_regs[ia], cpu_regs[ib]);
            end
            OP_JMP: npc = a;
            OP_JZ, OP_JG, OP_JL: begin
               neg = cmp_flag[31];
               take = (r.mode == OP_JZ) ? (cmp_flag == 0) :
                      (r.mode == OP_JG) ? (!neg && cmp_flag != 0) : neg;
               npc = take ? cpu_pc + 1 + a : cpu_pc + 2;
            end
            OP_OUT: if (ra) begin
               o.out_valid = 1'b1;
               o.out_value = cpu_regs[ia];
            end else o.error_code = ERR_BAD_REG;
            OP_INC: if (ra) cpu_regs[ia] = cpu_regs[ia] + 1; else o.error_code = ERR_BAD_REG;
            OP_DEC: if (ra) cpu_regs[ia] = cpu_regs[ia] - 1; else o.error_code = ERR_BAD_REG;
            default: begin
               o.error_code = ERR_UNKNOWN;
               cpu_stopped = 1'b1;
               npc = cpu_pc;
            end
         endcase
         cpu_pc = npc[15:0];
      end
      o.next_pc = cpu_pc;
      o.halted = cpu_stopped;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(execute_instr(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && $urandom_range(3) != 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               // now and then a long pause after this request
               if ($urandom_range(49) == 0) send_gap <= $urandom_range(40, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               failures++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.next_pc !== e.next_pc) begin
                  $error("next_pc exp %h got %h", e.next_pc, rsp_data.next_pc); failures++; end
               if (rsp_data.mem_write !== e.mem_write) begin
                  $error("mem_write exp %h got %h", e.mem_write, rsp_data.mem_write); failures++; end
               if (rsp_data.mem_addr !== e.mem_addr) begin
                  $error("mem_addr exp %h got %h", e.mem_addr, rsp_data.mem_addr); failures++; end
               if (rsp_data.mem_data !== e.mem_data) begin
                  $error("mem_data exp %h got %h", e.mem_data, rsp_data.mem_data); failures++; end
               if (rsp_data.out_valid !== e.out_valid) begin
                  $error("out_valid exp %h got %h", e.out_valid, rsp_data.out_valid); failures++; end
               if (rsp_data.out_value !== e.out_value) begin
                  $error("out_value exp %h got %h", e.out_value, rsp_data.out_value); failures++; end
               if (rsp_data.halted !== e.halted) begin
                  $error("halted exp %h got %h", e.halted, rsp_data.halted); failures++; end
               if (rsp_data.error_code !== e.error_code) begin
                  $error("error_code exp %h got %h", e.error_code, rsp_data.error_code); failures++; end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < 2) begin
            hold_off <= $urandom_range(60, 20);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(3) == 0);
         end
      end
      if (idle_cycles > 20000 && !run_done) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic add_req(logic [7:0] m, logic [31:0] a, logic [31:0] b,
                          logic [31:0] ld = 0, logic res = 1);
      req_type r;
      r.mode = m;
      r.operand_a = a;
      r.operand_b = b;
      r.load_data = ld;
      r.resume = res;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_START) begin
         cpu_pc = val;
         cpu_stopped = 1'b0;
      end else cfg_length = val;
   endtask

   // mostly valid registers; some bad indexes
   function automatic logic [31:0] reg_index();
      return ($urandom_range(9) == 0) ? $urandom : $urandom_range(3);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom_range(3);
         1: return 32'h8000_0000 | $urandom_range(1);
         2: return 32'hFFFF_FFFF - $urandom_range(1);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [7:0] m;
      for (int i = 0; i < count; i++) begin
         m = 8'($urandom_range(40) == 0 ? $urandom_range(255, 19) : $urandom_range(18));
         case (m)
            OP_HALT: add_req(m, $urandom, $urandom, $urandom, $urandom_range(7) != 0);
            OP_MOVRM: add_req(m, reg_index(),
               $urandom_range(1) ? $urandom :
                  $urandom_range(32'(cfg_length) + 1, 32'(cfg_length)),
               rand_word());
            OP_MOVRI: add_req(m, reg_index(), rand_word());
            OP_MOVMI, OP_MOVMR, OP_JMP: add_req(m, $urandom,
               m == OP_MOVMR ? reg_index() : $urandom);
            OP_JZ, OP_JG, OP_JL: add_req(m, $urandom_range(1) ? $urandom : $urandom_range(8),
               $urandom);
            default: add_req(m, reg_index(), reg_index(), $urandom, $urandom_range(1) != 0);
         endcase
      end
      // resume from any stop for the next phase
      drain();
      write_csr(CSR_START, 16'($urandom));
   endtask

   initial begin
      for (int i = 0; i < NumRegs; i++) cpu_regs[i] = '0;
      cmp_flag = '0;
      cpu_pc = '0;
      cpu_stopped = 1'b0;
      cfg_length = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_LENGTH, 16'd100);
      write_csr(CSR_START, 16'hFFFE);
      // directed: extremes, every opcode, each fault
      add_req(OP_MOVRI, 0, 32'h8000_0000);
      add_req(OP_MOVRI, 1, 32'hFFFF_FFFF);
      add_req(OP_DIV, 0, 1);                       // overflow wraps
      add_req(OP_MOVRI, 2, 0);
      add_req(OP_DIV, 1, 2);                       // divide by zero
      add_req(OP_MOVRI, 3, 32'd7);
      add_req(OP_DIV, 1, 3);
      add_req(OP_MUL, 3, 1);
      add_req(OP_ADD, 3, 1);
      add_req(OP_SUB, 0, 3);
      add_req(OP_MOVRR, 2, 3);
      add_req(OP_MOVRR, 4, 0);                     // bad register
      add_req(OP_MOVRM, 1, 100, 32'h1234);         // load in program area
      add_req(OP_MOVRM, 1, 101, 32'h8000_0001);
      add_req(OP_MOVMR, 32'hFFFF_FFFF, 1);
      add_req(OP_MOVMI, 32'h0001_0000, 32'hFFFF_FFFF);
      add_req(OP_CMP, 0, 0);
      add_req(OP_JZ, 32'hFFFF_FFFF, 0);
      add_req(OP_CMP, 0, 1);
      add_req(OP_JG, 5, 0);
      add_req(OP_JL, 5, 0);
      add_req(OP_OUT, 1, 0);
      add_req(OP_INC, 1, 0);
      add_req(OP_DEC, 0, 0);
      add_req(OP_JMP, 32'hFFFF_FFFF, 0);
      add_req(OP_NOP, 0, 0);
      add_req(OP_HALT, 0, 0, 0, 1'b0);
      add_req(OP_NOP, 0, 0);                       // ignored while stopped
      drain();
      write_csr(CSR_START, 16'd0);
      add_req(8'hFF, 0, 0);                        // unknown opcode
      add_req(OP_OUT, 0, 0);
      drain();
      write_csr(CSR_START, 16'h0000);
      write_csr(CSR_LENGTH, 16'hFFFF);
      random_phase(300);
      write_csr(CSR_LENGTH, 16'h0000);
      random_phase(700);
      write_csr(CSR_LENGTH, 16'($urandom));
      random_phase(1000);
      run_done = 1;
      if (failures == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
